FILE: design/rbdc_pkg.sv
// Package with request codes, the result record and defaults for the ring buffer DMA chunker.
`timescale 1ns / 1ps
`default_nettype none
package rbdc_pkg;

    localparam int BUF_DEPTH_DEFAULT = 256;

    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_DONE  = 2'd2;
    localparam logic [1:0] REQ_FETCH = 2'd3;

    typedef struct packed {
        logic       valid;
        logic       status;
        logic       launch;
        logic [7:0] offset;
        logic [8:0] count;
        logic [8:0] fill;
        logic       idle;
        logic       fetch;
    } rbdc_result_t;

endpackage
`default_nettype wire

FILE: design/ring_buffer_dma_chunker.sv
// Top level of the transmit ring buffer that hands contiguous chunks to a DMA engine.
//
//   Channel   Handshake        Payload
//   command   start / busy     req_type, data_byte, fetch_index
//   result    done (strobe)    status, launch, launch_offset, launch_count,
//                              read_data, fill_level, engine_idle
//
// Every transaction is registered, and its result appears in the next cycle.
// Busy is never raised, so a command may be issued in every cycle.
// The rate is set by the single byte store write port and one registered read port.
// Reset clears the indices, the fill level and the chunk size and leaves the engine idle.
// The byte store is not cleared; the receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none
module ring_buffer_dma_chunker #(
    parameter int BUF_DEPTH = rbdc_pkg::BUF_DEPTH_DEFAULT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] req_type,
    input  wire logic [7:0] data_byte,
    input  wire logic [7:0] fetch_index,
    output logic            done,
    output logic            status,
    output logic            launch,
    output logic [7:0]      launch_offset,
    output logic [8:0]      launch_count,
    output logic [7:0]      read_data,
    output logic [8:0]      fill_level,
    output logic            engine_idle
);
    import rbdc_pkg::*;

    localparam int AW = $clog2(BUF_DEPTH);

    logic          accept;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [7:0]    rd_data;
    rbdc_result_t  result;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    rbdc_ctrl #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .req_type (req_type),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .rd_en    (rd_en),
        .result   (result)
    );

    rbdc_store #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (data_byte),
        .rd_en     (rd_en),
        .rd_offset (fetch_index),
        .rd_data   (rd_data)
    );

    assign done          = result.valid;
    assign status        = result.status;
    assign launch        = result.launch;
    assign launch_offset = result.offset;
    assign launch_count  = result.count;
    assign read_data     = result.fetch ? rd_data : 8'd0;
    assign fill_level    = result.fill;
    assign engine_idle   = result.idle;

    // A launched chunk leaves the engine busy.
    a_launch_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (done && launch) |-> !engine_idle)
        else $error("launch reported with the engine idle");

    // A launched chunk is never empty and never exceeds the fill level.
    a_launch_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && launch && BUF_DEPTH <= 256) |->
            (launch_count != 9'd0 && launch_count <= fill_level))
        else $error("launched chunk size out of range");

    // Every accepted transaction gives exactly one result in the next cycle.
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("accepted transaction without a result");

    // Overflow is only reported by a result that launches nothing.
    a_overflow_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (!launch && read_data == 8'd0))
        else $error("overflow result carries other activity");

endmodule
`default_nettype wire

FILE: design/rbdc_store.sv
// Byte store of the ring buffer with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module rbdc_store #(
    parameter int BUF_DEPTH = rbdc_pkg::BUF_DEPTH_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         wr_en,
    input  wire logic [$clog2(BUF_DEPTH)-1:0] wr_addr,
    input  wire logic [7:0]                   wr_data,
    input  wire logic                         rd_en,
    input  wire logic [7:0]                   rd_offset,
    output logic [7:0]                        rd_data
);
    import rbdc_pkg::*;

    localparam int AW = $clog2(BUF_DEPTH);

    logic [7:0]    byte_store_mem [BUF_DEPTH];
    logic [AW-1:0] fold_tab [256];
    logic [7:0]    rd_data_reg;

    // The fetch offset wraps modulo the depth; the table is fixed at elaboration.
    for (genvar i = 0; i < 256; i++) begin : g_fold
        assign fold_tab[i] = AW'(i % BUF_DEPTH);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            byte_store_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= byte_store_mem[fold_tab[rd_offset]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

FILE: design/rbdc_ctrl.sv
// Index, fill and chunk bookkeeping of the ring buffer, with the registered result record.
`timescale 1ns / 1ps
`default_nettype none
module rbdc_ctrl #(
    parameter int BUF_DEPTH = rbdc_pkg::BUF_DEPTH_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         accept,
    input  wire logic [1:0]                   req_type,
    output logic                              wr_en,
    output logic [$clog2(BUF_DEPTH)-1:0]      wr_addr,
    output logic                              rd_en,
    output rbdc_pkg::rbdc_result_t            result
);
    import rbdc_pkg::*;

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int CW = $clog2(BUF_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(BUF_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(BUF_DEPTH - 1);

    logic [AW-1:0] write_index_reg, write_index_next;
    logic [AW-1:0] read_index_reg, read_index_next;
    logic [CW-1:0] held_count_reg, held_count_next;
    logic [CW-1:0] chunk_size_reg, chunk_size_next;
    logic          idle_reg, idle_next;
    rbdc_result_t  result_reg, result_next;

    logic [CW-1:0] held_after;
    logic [CW-1:0] read_sum;
    logic [AW-1:0] read_after;
    logic [AW-1:0] base_read;
    logic [CW-1:0] base_held;
    logic [CW-1:0] to_end;
    logic [CW-1:0] candidate;
    logic          launched;
    logic          full;

    always_comb
    begin
        full       = (held_count_reg == DEPTH_C);
        held_after = held_count_reg - chunk_size_reg;
        read_sum   = CW'(read_index_reg) + chunk_size_reg;
        read_after = (read_sum == DEPTH_C) ? '0 : read_sum[AW-1:0];
        base_read  = (req_type == REQ_DONE) ? read_after : read_index_reg;
        base_held  = (req_type == REQ_DONE) ? held_after : held_count_reg;
        to_end     = DEPTH_C - CW'(base_read);
        candidate  = (base_held < to_end) ? base_held : to_end;

        write_index_next = write_index_reg;
        read_index_next  = read_index_reg;
        held_count_next  = held_count_reg;
        chunk_size_next  = chunk_size_reg;
        idle_next        = idle_reg;
        launched         = 1'b0;
        wr_en            = 1'b0;
        rd_en            = 1'b0;
        wr_addr          = write_index_reg;
        result_next      = result_reg;
        result_next.valid = 1'b0;

        if (accept)
        begin
            unique case (req_type)
                REQ_PUT:
                begin
                    if (!full)
                    begin
                        wr_en            = 1'b1;
                        write_index_next = (write_index_reg == LAST_IDX) ? '0
                                         : write_index_reg + AW'(1);
                        held_count_next  = held_count_reg + CW'(1);
                    end
                end
                REQ_START:
                begin
                    if (idle_reg)
                    begin
                        chunk_size_next = candidate;
                        if (candidate != '0)
                        begin
                            idle_next = 1'b0;
                            launched  = 1'b1;
                        end
                    end
                end
                REQ_DONE:
                begin
                    if (!idle_reg)
                    begin
                        held_count_next = held_after;
                        read_index_next = read_after;
                        if (held_after == '0)
                        begin
                            idle_next = 1'b1;
                        end
                        else
                        begin
                            chunk_size_next = candidate;
                            if (candidate != '0)
                            begin
                                launched = 1'b1;
                            end
                            else
                            begin
                                idle_next = 1'b1;
                            end
                        end
                    end
                end
                REQ_FETCH:
                begin
                    rd_en = 1'b1;
                end
                default:
                begin
                    rd_en = 1'b0;
                end
            endcase

            result_next.valid  = 1'b1;
            result_next.status = (req_type == REQ_PUT) && full;
            result_next.launch = launched;
            result_next.offset = launched ? 8'(read_index_next) : 8'd0;
            result_next.count  = launched ? 9'(chunk_size_next) : 9'd0;
            result_next.fill   = 9'(held_count_next);
            result_next.idle   = idle_next;
            result_next.fetch  = (req_type == REQ_FETCH);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_index_reg <= '0;
            read_index_reg  <= '0;
            held_count_reg  <= '0;
            chunk_size_reg  <= '0;
            idle_reg        <= 1'b1;
            result_reg      <= '0;
        end
        else
        begin
            write_index_reg <= write_index_next;
            read_index_reg  <= read_index_next;
            held_count_reg  <= held_count_next;
            chunk_size_reg  <= chunk_size_next;
            idle_reg        <= idle_next;
            result_reg      <= result_next;
        end
    end

    assign result = result_reg;

endmodule
`default_nettype wire
